/* rtl/core/lcdn_pkg.sv */
// Shared types, codes and step tables for the character LCD nibble interface.
`default_nettype none

package lcdn_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WAIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WAIT   = 2'd2;

   // Request codes
   localparam logic [2:0] CMD_BYTE   = 3'd0;
   localparam logic [2:0] CMD_CHAR   = 3'd1;
   localparam logic [2:0] CMD_CURSOR = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_INIT   = 3'd4;

   // Fixed command bytes
   localparam logic [7:0] LCD_CMD_CLEAR = 8'h01;
   localparam logic [7:0] LCD_HOME      = 8'h02;
   localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
   localparam logic [7:0] LCD_ROW1_BASE = 8'h40;

   // Hold time selection for one step
   localparam logic [2:0] HK_PULSE      = 3'd0;  // pulse width
   localparam logic [2:0] HK_SHORT      = 3'd1;  // short wait
   localparam logic [2:0] HK_TWO_SHORT  = 3'd2;  // short + short
   localparam logic [2:0] HK_SHORT_LONG = 3'd3;  // short + long
   localparam logic [2:0] HK_SHORT_5000 = 3'd4;  // short + 5000
   localparam logic [2:0] HK_SHORT_200  = 3'd5;  // short + 200
   localparam logic [2:0] HK_IDLE       = 3'd6;  // power-up idle, 50000
   localparam logic [2:0] HK_INIT_CLR   = 3'd7;  // short + long + 2000

   localparam logic [15:0] HOLD_IDLE_US   = 16'd50000;
   localparam logic [15:0] HOLD_5000_US   = 16'd5000;
   localparam logic [15:0] HOLD_200_US    = 16'd200;
   localparam logic [15:0] HOLD_INIT_X_US = 16'd2000;

   localparam logic [4:0] INIT_LAST_STEP = 5'd24;
   localparam logic [1:0] BYTE_LAST_STEP = 2'd3;

   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] byte_val;
      logic       long_settle;
   } desc_type;

   typedef struct packed {
      logic [7:0]  pulse_width_us;
      logic [9:0]  short_wait_us;
      logic [13:0] long_wait_us;
   } cfg_type;

   typedef struct packed {
      logic       rs;
      logic       en;
      logic [3:0] nib;
      logic [2:0] kind;
      logic       last;
   } step_type;

   function automatic step_type mk_step(input logic en, input logic [3:0] nib,
                                        input logic [2:0] kind, input logic last);
      step_type s;
      s.rs   = 1'b0;
      s.en   = en;
      s.nib  = nib;
      s.kind = kind;
      s.last = last;
      return s;
   endfunction

   // Power-up sequence, one entry per step
   function automatic step_type init_step(input logic [4:0] idx);
      step_type s;
      case (idx)
         5'd0:  s = mk_step(1'b0, 4'h0, HK_IDLE,       1'b0);
         5'd1:  s = mk_step(1'b1, 4'h3, HK_PULSE,      1'b0);
         5'd2:  s = mk_step(1'b0, 4'h3, HK_SHORT_5000, 1'b0);
         5'd3:  s = mk_step(1'b1, 4'h3, HK_PULSE,      1'b0);
         5'd4:  s = mk_step(1'b0, 4'h3, HK_SHORT_200,  1'b0);
         5'd5:  s = mk_step(1'b1, 4'h3, HK_PULSE,      1'b0);
         5'd6:  s = mk_step(1'b0, 4'h3, HK_SHORT_200,  1'b0);
         5'd7:  s = mk_step(1'b1, 4'h2, HK_PULSE,      1'b0);
         5'd8:  s = mk_step(1'b0, 4'h2, HK_SHORT_200,  1'b0);
         5'd9:  s = mk_step(1'b1, 4'h2, HK_PULSE,      1'b0);
         5'd10: s = mk_step(1'b0, 4'h2, HK_SHORT,      1'b0);
         5'd11: s = mk_step(1'b1, 4'h8, HK_PULSE,      1'b0);
         5'd12: s = mk_step(1'b0, 4'h8, HK_TWO_SHORT,  1'b0);
         5'd13: s = mk_step(1'b1, 4'h0, HK_PULSE,      1'b0);
         5'd14: s = mk_step(1'b0, 4'h0, HK_SHORT,      1'b0);
         5'd15: s = mk_step(1'b1, 4'hC, HK_PULSE,      1'b0);
         5'd16: s = mk_step(1'b0, 4'hC, HK_TWO_SHORT,  1'b0);
         5'd17: s = mk_step(1'b1, 4'h0, HK_PULSE,      1'b0);
         5'd18: s = mk_step(1'b0, 4'h0, HK_SHORT,      1'b0);
         5'd19: s = mk_step(1'b1, 4'h6, HK_PULSE,      1'b0);
         5'd20: s = mk_step(1'b0, 4'h6, HK_TWO_SHORT,  1'b0);
         5'd21: s = mk_step(1'b1, 4'h0, HK_PULSE,      1'b0);
         5'd22: s = mk_step(1'b0, 4'h0, HK_SHORT,      1'b0);
         5'd23: s = mk_step(1'b1, 4'h1, HK_PULSE,      1'b0);
         5'd24: s = mk_step(1'b0, 4'h1, HK_INIT_CLR,   1'b1);
         default: s = mk_step(1'b0, 4'h0, HK_IDLE,     1'b0);
      endcase
      return s;
   endfunction

   // One byte: high nibble first, enable-high then enable-low per nibble
   function automatic step_type byte_step(input desc_type d, input logic [1:0] pos);
      step_type s;
      s.rs  = d.rs;
      s.en  = ~pos[0];
      s.nib = pos[1] ? d.byte_val[3:0] : d.byte_val[7:4];
      if (!pos[0]) begin
         s.kind = HK_PULSE;
      end else if (!pos[1]) begin
         s.kind = HK_SHORT;
      end else begin
         s.kind = d.long_settle ? HK_SHORT_LONG : HK_TWO_SHORT;
      end
      s.last = (pos == BYTE_LAST_STEP);
      return s;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/lcdn_if.sv */
// Request and response channel interfaces of the character LCD nibble interface.
`default_nettype none

interface lcdn_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] byte_value;
   logic       row;
   logic [5:0] col;

   modport source (output valid, output cmd, output byte_value, output row,
                   output col, input ready);
   modport sink   (input valid, input cmd, input byte_value, input row,
                   input col, output ready);
endinterface

interface lcdn_rsp_if;
   logic        valid;
   logic        ready;
   logic        reg_select;
   logic        enable;
   logic [3:0]  data_nibble;
   logic [15:0] hold_us;
   logic        last;

   modport source (output valid, output reg_select, output enable,
                   output data_nibble, output hold_us, output last, input ready);
   modport sink   (input valid, input reg_select, input enable,
                   input data_nibble, input hold_us, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/char_lcd_nibble_interface_top.sv */
// Top level of the character LCD 4-bit nibble interface.
// First pin step of a request goes via front, queue, sequencer and output registers.
// Throughput: one pin step per cycle while the response side is ready; a byte request
//   gives 4 steps, power-up init gives 25; other codes give none.
// Requests keep entering through the front register and queue while steps drain.
// Reset (synchronous): clears all handshake and sequencer state, loads the timing
//   registers with pulse 1 us, short wait 50 us, long wait 2000 us.
`default_nettype none

module char_lcd_nibble_interface_top
   import lcdn_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lcdn_req_if.sink                   req_ch,
   lcdn_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Timing registers
   logic [7:0]  pulse_ff;
   logic [9:0]  short_ff;
   logic [13:0] long_ff;
   cfg_type     cfg;

   // Front to queue, queue to sequencer
   logic     push_valid, push_ready;
   desc_type push_data;
   logic     pop_valid, pop_ready;
   desc_type pop_data;

   // Take register writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= 8'd1;
         short_ff <= 10'd50;
         long_ff  <= 14'd2000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PULSE_WIDTH: pulse_ff <= csr_wdata[7:0];
            CSR_SHORT_WAIT:  short_ff <= csr_wdata[9:0];
            CSR_LONG_WAIT:   long_ff  <= csr_wdata[13:0];
            default:         pulse_ff <= pulse_ff;
         endcase
      end
   end

   assign cfg.pulse_width_us = pulse_ff;
   assign cfg.short_wait_us  = short_ff;
   assign cfg.long_wait_us   = long_ff;

   // Classify requests and form the byte to send
   lcdn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Buffer descriptors so the front keeps accepting while steps go out
   lcdn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Expand each descriptor into timed pin steps
   lcdn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_ch)
   );

   // Nothing is offered in the cycle after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

   // An enable-high step never ends a request
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.enable |-> !rsp_ch.last)
      else $error("last flag on an enable-high step");

   // Steps with enable high hold for the pulse width only
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.enable && !csr_we && !$past(csr_we)
         |-> rsp_ch.hold_us == {8'b0, pulse_ff})
      else $error("enable-high step hold differs from pulse width");

endmodule

`default_nettype wire

/* rtl/core/lcdn_front.sv */
// Request front end: accept, classify into a byte or power-up descriptor.
`default_nettype none

module lcdn_front
   import lcdn_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   lcdn_req_if.sink   req,
   output logic       push_valid,
   input  wire logic  push_ready,
   output desc_type   push_data
);

   logic     valid_ff, valid_in;
   desc_type desc_ff, desc_in;
   logic     accept, known;

   assign req.ready  = !valid_ff || push_ready;
   assign accept     = req.valid && req.ready;
   assign push_valid = valid_ff;
   assign push_data  = desc_ff;

   always_comb begin
      known = req.cmd inside {[CMD_BYTE:CMD_INIT]};
      desc_in.is_init  = 1'b0;
      desc_in.rs       = 1'b0;
      desc_in.byte_val = req.byte_value;
      case (req.cmd)
         CMD_BYTE:   desc_in.byte_val = req.byte_value;
         CMD_CHAR:   desc_in.rs = 1'b1;
         CMD_CURSOR: desc_in.byte_val = LCD_SET_DDRAM |
                        ((req.row ? LCD_ROW1_BASE : 8'h00) + {2'b00, req.col});
         CMD_CLEAR:  desc_in.byte_val = LCD_CMD_CLEAR;
         CMD_INIT:   desc_in.is_init = 1'b1;
         default:    desc_in.is_init = 1'b0;
      endcase
      desc_in.long_settle = !desc_in.rs &&
         (desc_in.byte_val == LCD_CMD_CLEAR || desc_in.byte_val == LCD_HOME);
      // drop undefined codes here
      valid_in = (valid_ff && !push_ready) || (accept && known);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/lcdn_queue.sv */
// Descriptor queue between the front end and the step sequencer.
`default_nettype none

module lcdn_queue
   import lcdn_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire desc_type  push_data,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output desc_type       pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   desc_type         mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/lcdn_back.sv */
// Step sequencer: expands descriptors into timed pin steps, one per cycle while ready.
`default_nettype none

module lcdn_back
   import lcdn_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      pop_valid,
   output logic           pop_ready,
   input  wire desc_type  pop_data,
   lcdn_rsp_if.source     rsp
);

   logic        busy_ff, busy_in;
   logic [4:0]  step_ff, step_in;
   desc_type    desc_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   step_type    out_ff, cur;
   logic [15:0] hold_ff, hold;
   logic        advance, final_step, emit, load;
   logic [15:0] sw, lw, pw;

   assign advance    = !rsp_valid_ff || rsp.ready;
   assign emit       = busy_ff && advance;
   assign final_step = desc_ff.is_init ? (step_ff == INIT_LAST_STEP)
                                       : (step_ff[1:0] == BYTE_LAST_STEP);
   assign pop_ready  = !busy_ff || (emit && final_step);
   assign load       = pop_valid && pop_ready;

   assign sw = {6'b0, cfg.short_wait_us};
   assign lw = {2'b0, cfg.long_wait_us};
   assign pw = {8'b0, cfg.pulse_width_us};

   always_comb begin
      cur = desc_ff.is_init ? init_step(step_ff) : byte_step(desc_ff, step_ff[1:0]);
      cur.rs = desc_ff.is_init ? 1'b0 : desc_ff.rs;
      case (cur.kind)
         HK_PULSE:      hold = pw;
         HK_SHORT:      hold = sw;
         HK_TWO_SHORT:  hold = sw + sw;
         HK_SHORT_LONG: hold = sw + lw;
         HK_SHORT_5000: hold = sw + HOLD_5000_US;
         HK_SHORT_200:  hold = sw + HOLD_200_US;
         HK_IDLE:       hold = HOLD_IDLE_US;
         HK_INIT_CLR:   hold = sw + lw + HOLD_INIT_X_US;
         default:       hold = HOLD_IDLE_US;
      endcase

      busy_in = busy_ff;
      step_in = step_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (emit) begin
         busy_in = !final_step;
         step_in = 5'(step_ff + 5'd1);
      end
      rsp_valid_in = advance ? busy_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff <= pop_data;
      end
      if (emit) begin
         out_ff  <= cur;
         hold_ff <= hold;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.reg_select  = out_ff.rs;
   assign rsp.enable      = out_ff.en;
   assign rsp.data_nibble = out_ff.nib;
   assign rsp.hold_us     = hold_ff;
   assign rsp.last        = out_ff.last;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the character LCD 4-bit nibble interface top level.
`timescale 1ns / 100ps

module testbench;
   import lcdn_pkg::*;

   // Register index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // First request code that the block ignores
   localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
   localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

   // Power-up command bytes and wake-up nibbles
   localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
   localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
   localparam logic [3:0] LCD_WAKE_NIB   = 4'h3;
   localparam logic [3:0] LCD_4BIT_NIB   = 4'h2;

   localparam int RESET_CYCLES = 12;
   localparam int LATENCY_PAD  = 10;      // pads past the last owed step so the pipeline goes quiet
   localparam int IDLE_PCT     = 6;
   localparam int TIMEOUT_NS   = 400_000;

   typedef struct packed {
      logic        rs;
      logic        en;
      logic [3:0]  nib;
      logic [15:0] hold;
      logic        last;
   } pin_step_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lcdn_req_if req_bus ();
   lcdn_rsp_if rsp_bus ();

   char_lcd_nibble_interface_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Timing registers as the block should hold them
   logic [7:0]  pulse_us;
   logic [9:0]  short_us;
   logic [13:0] long_us;

   // Pin steps still owed by the block, oldest first
   pin_step_type pin_steps_due[$];
   pin_step_type step_due;

   int errors;
   int req_idle_pct;
   int rsp_idle_pct;

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Step predictor: expand one request into the pin steps it must cause
   // ------------------------------------------------------------------
   function automatic void queue_step(logic rs, logic en, logic [3:0] nib,
                                      int unsigned hold, logic last);
      pin_step_type s;
      s.rs   = rs;
      s.en   = en;
      s.nib  = nib;
      s.hold = hold[15:0];
      s.last = last;
      pin_steps_due.push_back(s);
   endfunction

   // Enable-high step for the pulse, then enable-low step for the settle
   function automatic void queue_nibble(logic rs, logic [3:0] nib, int unsigned extra,
                                        logic last);
      queue_step(rs, 1'b1, nib, pulse_us, 1'b0);
      queue_step(rs, 1'b0, nib, short_us + extra, last);
   endfunction

   function automatic void queue_byte(logic rs, logic [7:0] b, int unsigned extra,
                                      logic last);
      queue_nibble(rs, b[7:4], 0, 1'b0);
      queue_nibble(rs, b[3:0], extra, last);
   endfunction

   // Clear and home need the long settle, everything else the short one
   function automatic int unsigned settle_for(logic [7:0] b);
      return (b == LCD_CMD_CLEAR || b == LCD_HOME) ? long_us : short_us;
   endfunction

   function automatic void queue_command(logic [7:0] b, logic last);
      queue_byte(1'b0, b, settle_for(b), last);
   endfunction

   function automatic void predict_request(logic [2:0] cmd, logic [7:0] b, logic row,
                                           logic [5:0] col);
      logic [7:0] base;
      base = row ? LCD_ROW1_BASE : 8'h00;
      case (cmd)
         CMD_BYTE:   queue_command(b, 1'b1);
         CMD_CHAR:   queue_byte(1'b1, b, short_us, 1'b1);
         // Column is not clamped; row base plus column never exceeds 7 bits
         CMD_CURSOR: queue_command(LCD_SET_DDRAM | 8'(base + col), 1'b1);
         CMD_CLEAR:  queue_command(LCD_CMD_CLEAR, 1'b1);
         CMD_INIT: begin
            queue_step(1'b0, 1'b0, 4'h0, HOLD_IDLE_US, 1'b0);
            queue_nibble(1'b0, LCD_WAKE_NIB, HOLD_5000_US, 1'b0);
            queue_nibble(1'b0, LCD_WAKE_NIB, HOLD_200_US, 1'b0);
            queue_nibble(1'b0, LCD_WAKE_NIB, HOLD_200_US, 1'b0);
            queue_nibble(1'b0, LCD_4BIT_NIB, HOLD_200_US, 1'b0);
            queue_command(LCD_FUNC_4BIT, 1'b0);
            queue_command(LCD_DISPLAY_ON, 1'b0);
            queue_command(LCD_ENTRY_MODE, 1'b0);
            queue_byte(1'b0, LCD_CMD_CLEAR, settle_for(LCD_CMD_CLEAR) + HOLD_INIT_X_US,
                       1'b1);
         end
         default: ;  // undefined codes produce nothing
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Response side: random back-pressure and the step checker
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp, act);
         errors++;
      end
   endfunction

   // Compare every accepted step against the oldest owed step
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pin_steps_due.size() == 0) begin
            $display({"%0t: unexpected step: expected none, ",
                      "actual rs=%0d en=%0d nib=%h hold=%0d last=%0d"},
                     $time, rsp_bus.reg_select, rsp_bus.enable, rsp_bus.data_nibble,
                     rsp_bus.hold_us, rsp_bus.last);
            errors++;
         end else begin
            step_due = pin_steps_due.pop_front();
            check_field("reg_select",  step_due.rs,   rsp_bus.reg_select);
            check_field("enable",      step_due.en,   rsp_bus.enable);
            check_field("data_nibble", step_due.nib,  rsp_bus.data_nibble);
            check_field("hold_us",     step_due.hold, rsp_bus.hold_us);
            check_field("last",        step_due.last, rsp_bus.last);
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side and configuration helpers
   // ------------------------------------------------------------------

   // Present one request, hold it until accepted, then predict its steps.
   // Valid stays high on return so the next request can follow back to back.
   task automatic send_request(logic [2:0] cmd, logic [7:0] b, logic row, logic [5:0] col);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.byte_value <= b;
      req_bus.row        <= row;
      req_bus.col        <= col;
      do @(posedge clock); while (!req_bus.ready);
      predict_request(cmd, b, row, col);
   endtask

   // Drop valid, wait for every owed step, then let the pipeline go quiet
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pin_steps_due.size() != 0) @(posedge clock);
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   // Write one register and track it; only call while the block is idle
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_PULSE_WIDTH: pulse_us = data[7:0];
         CSR_SHORT_WAIT:  short_us = data[9:0];
         CSR_LONG_WAIT:   long_us  = data[13:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_timing(int unsigned pulse, int unsigned short_w, int unsigned long_w);
      settle_block();
      write_csr(CSR_PULSE_WIDTH, CSR_DATA_W'(pulse));
      write_csr(CSR_SHORT_WAIT,  CSR_DATA_W'(short_w));
      write_csr(CSR_LONG_WAIT,   CSR_DATA_W'(long_w));
   endtask

   // One random request, mostly well formed; counted is low for ignored codes
   task automatic send_random(output bit counted);
      int unsigned pick;
      logic [2:0]  cmd;
      logic [7:0]  b;
      logic        row;
      logic [5:0]  col;
      pick    = $urandom_range(0, 99);
      b       = 8'($urandom);
      row     = 1'($urandom);
      col     = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 39))
                                             : 6'($urandom_range(40, 63));
      counted = 1'b1;
      if (pick < 35) begin
         cmd = CMD_BYTE;
         // Steer some bytes onto clear and home to hit the long settle
         if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? LCD_CMD_CLEAR : LCD_HOME;
      end else if (pick < 70) begin
         cmd = CMD_CHAR;
      end else if (pick < 88) begin
         cmd = CMD_CURSOR;
      end else if (pick < 93) begin
         cmd = CMD_CLEAR;
      end else if (pick < 96) begin
         cmd = CMD_INIT;
      end else begin
         cmd     = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
         counted = 1'b0;
      end
      send_request(cmd, b, row, col);
   endtask

   task automatic run_random(int n);
      int sent;
      bit counted;
      sent = 0;
      while (sent < n) begin
         send_random(counted);
         if (counted) sent++;
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, every request code and the special bytes at reset timing
   task automatic test_reset_defaults();
      send_request(CMD_BYTE, 8'h00, 1'b0, 6'd0);
      send_request(CMD_BYTE, 8'hFF, 1'b1, 6'd63);
      send_request(CMD_BYTE, LCD_CMD_CLEAR, 1'b0, 6'd0);
      send_request(CMD_BYTE, LCD_HOME, 1'b0, 6'd0);
      send_request(CMD_BYTE, 8'h03, 1'b0, 6'd0);
      send_request(CMD_CHAR, 8'h00, 1'b0, 6'd0);
      send_request(CMD_CHAR, 8'hFF, 1'b1, 6'd63);
      send_request(CMD_CHAR, 8'hA5, 1'b0, 6'd21);
      send_request(CMD_CURSOR, 8'h00, 1'b0, 6'd0);
      send_request(CMD_CURSOR, 8'h00, 1'b1, 6'd39);
      send_request(CMD_CURSOR, 8'hFF, 1'b0, 6'd40);
      send_request(CMD_CURSOR, 8'h00, 1'b1, 6'd63);
      send_request(CMD_CLEAR, 8'h5A, 1'b1, 6'd17);
      send_request(CMD_INIT, 8'hC3, 1'b0, 6'd5);
      // Ignored codes between real requests must leave no trace
      send_request(3'd5, 8'hFF, 1'b1, 6'd63);
      send_request(CMD_CHAR, 8'h41, 1'b0, 6'd0);
      send_request(3'd6, 8'h00, 1'b0, 6'd0);
      send_request(3'd7, 8'h81, 1'b1, 6'd33);
      send_request(CMD_BYTE, 8'h80, 1'b0, 6'd0);
   endtask

   // Minimum, maximum and zero settings of all three timing registers
   task automatic test_timing_extremes();
      apply_timing(1, 1, 1);
      run_random(70);
      apply_timing(255, 1023, 16383);
      send_request(CMD_INIT, 8'h00, 1'b0, 6'd0);
      run_random(70);
      // Zero is taken as is, so holds of zero must appear
      apply_timing(0, 0, 0);
      run_random(50);
   endtask

   // Upper write-data bits beyond a register's width must be dropped
   task automatic test_register_truncation();
      settle_block();
      write_csr(CSR_PULSE_WIDTH, 14'h3FA5);
      write_csr(CSR_SHORT_WAIT,  14'h3D55);
      write_csr(CSR_LONG_WAIT,   CSR_DATA_W'($urandom));
      // Hit the unmapped index; it must not disturb any register
      write_csr(CSR_UNUSED, 14'h2AAA);
      run_random(60);
   endtask

   task automatic test_random_timing();
      repeat (3) begin
         apply_timing($urandom_range(1, 255), $urandom_range(1, 1023),
                      $urandom_range(1, 16383));
         run_random(40);
      end
   endtask

   // Long stretch with both sides always willing
   task automatic test_back_to_back();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(80);
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
   endtask

   // Hold off the sender until every owed step has drained, then resume
   task automatic test_drain_pause();
      run_random(20);
      settle_block();
      run_random(20);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      errors             = 0;
      req_idle_pct       = IDLE_PCT;
      rsp_idle_pct       = IDLE_PCT;
      pulse_us           = 8'd1;
      short_us           = 10'd50;
      long_us            = 14'd2000;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_PULSE_WIDTH;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_BYTE;
      req_bus.byte_value = 8'h00;
      req_bus.row        = 1'b0;
      req_bus.col        = 6'd0;
      rsp_bus.ready      = 1'b0;

      // Hold reset, then release it away from the sampling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_timing_extremes();
      test_register_truncation();
      test_random_timing();
      test_back_to_back();
      test_drain_pause();

      // Drain and watch a little longer for stray steps
      settle_block();
      if (errors == 0 && pin_steps_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (pin_steps_due.size() != 0)
            $display("%0t: %0d steps never arrived", $time, pin_steps_due.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout with %0d steps owed", $time, pin_steps_due.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
